/* hdl/text_console_cursor_control_unit_assert.svh */
// assertion macros for the text console cursor control checker
// no dependencies; included by the checker file
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_UNIT_ASSERT_SVH

// same-cycle implication
`define TCCC_ASSERT_IMPLY(label, clk_sig, rst_sig, pre, post, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define TCCC_ASSERT_NEXT(label, clk_sig, rst_sig, pre, post, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/tccc_pkg.sv */
// shared types and constants for the text console cursor control unit
// no dependencies
package tccc_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 128;
    localparam int MAX_ROWS_DEFAULT    = 64;
    localparam int TAB_STOP_DEFAULT    = 4;

    localparam int CHAR_W   = 8;
    localparam int COLCFG_W = 8;
    localparam int ROWCFG_W = 7;
    localparam int COLOR_W  = 24;
    localparam int KIND_W   = 2;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 6;
    localparam int POS_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [COLCFG_W-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [ROWCFG_W-1:0] ROWS_RESET    = 7'd25;
    localparam logic [COLOR_W-1:0]  COLOR_RESET   = 24'hFFFFFF;

    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CURSOR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [CHAR_W-1:0]   glyph_code;
        logic [COLOR_W-1:0]  foreground;
        logic [POS_W-1:0]    cursor_position;
        logic                last;
    } result_t;

endpackage

/* hdl/text_console_cursor_control_unit.sv */
// text console cursor control: sequencer, cursor state, config and result register
// depends on tccc_pkg and tccc_rem
//
// One character item is taken while the block is idle; a small sequencer then
// produces its results one at a time through a single output register and is not
// ready again until the closing cursor update has been loaded. A printable byte
// passes idle, decode, cell write, wrap/scroll, row times width multiply and
// cursor update; carriage return and line feed skip the cell write. A tab first
// waits in the reciprocal remainder unit and then repeats cell write and
// wrap/scroll once per fill space, one to TAB_STOP spaces. A consumer that stalls
// the output register holds the sequencer until the result is taken.
module text_console_cursor_control_unit #(
    parameter int MAX_COLUMNS = tccc_pkg::MAX_COLUMNS_DEFAULT,
    parameter int MAX_ROWS    = tccc_pkg::MAX_ROWS_DEFAULT,
    parameter int TAB_STOP    = tccc_pkg::TAB_STOP_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tccc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tccc_pkg::COLOR_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tccc_pkg::CHAR_W-1:0]      character,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tccc_pkg::KIND_W-1:0]      kind,
    output logic [tccc_pkg::COLUMN_W-1:0]    column,
    output logic [tccc_pkg::ROW_W-1:0]       row,
    output logic [tccc_pkg::CHAR_W-1:0]      glyph_code,
    output logic [tccc_pkg::COLOR_W-1:0]     foreground,
    output logic [tccc_pkg::POS_W-1:0]       cursor_position,
    output logic                             last
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int TW = $clog2(TAB_STOP + 1);
    localparam int PW = CW + RW;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_TAB    = 7'b0000100,
        ST_PUT    = 7'b0001000,
        ST_SETTLE = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_CURSOR = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [tccc_pkg::COLCFG_W-1:0] cols_cfg_reg;
    logic [tccc_pkg::ROWCFG_W-1:0] rows_cfg_reg;
    logic [tccc_pkg::COLOR_W-1:0]  color_reg;

    logic [CW-1:0] cols_eff;
    logic [RW-1:0] rows_eff;
    logic [8:0]    cols_ext;
    logic [8:0]    rows_ext;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [TW-1:0] cnt_reg, cnt_next;
    logic [tccc_pkg::CHAR_W-1:0] ch_reg;
    logic [PW-1:0] prod_reg;
    logic [PW:0]   pos_sum;

    logic          accept;
    logic          out_free;
    logic          emit;
    logic          rem_start;
    logic          rem_done;
    logic [TW-1:0] rem_value;
    logic [CW-1:0] col_wrap;
    logic [RW-1:0] row_wrap;
    logic          wrap;
    logic [tccc_pkg::CHAR_W-1:0] glyph;

    tccc_pkg::result_t res_reg, res_next;
    logic              out_valid_reg;

    tccc_rem #(
        .DIVISOR (TAB_STOP),
        .WIDTH   (CW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (col_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    assign cols_ext = {1'b0, cols_cfg_reg};
    assign rows_ext = {2'b00, rows_cfg_reg};
    assign cols_eff = (cols_cfg_reg == '0) ? CW'(1)
                    : (cols_ext > 9'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cols_cfg_reg);
    assign rows_eff = (rows_cfg_reg == '0) ? RW'(1)
                    : (rows_ext > 9'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_cfg_reg);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign wrap     = (col_reg >= cols_eff);
    assign col_wrap = wrap ? '0 : col_reg;
    assign row_wrap = wrap ? row_reg + RW'(1) : row_reg;
    assign glyph    = (ch_reg == tccc_pkg::CHAR_TAB) ? tccc_pkg::CHAR_SPACE : ch_reg;
    assign pos_sum  = {1'b0, prod_reg} + (PW+1)'(col_reg);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        rem_start  = 1'b0;
        emit       = 1'b0;
        res_next.kind            = tccc_pkg::KIND_WRITE;
        res_next.column          = tccc_pkg::COLUMN_W'(col_reg);
        res_next.row             = tccc_pkg::ROW_W'(row_reg);
        res_next.glyph_code      = glyph;
        res_next.foreground      = color_reg;
        res_next.cursor_position = '0;
        res_next.last            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_next   = (col_reg >= cols_eff) ? cols_eff - CW'(1) : col_reg;
                    row_next   = (row_reg >= rows_eff) ? rows_eff - RW'(1) : row_reg;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (ch_reg)
                    tccc_pkg::CHAR_LF:
                    begin
                        col_next   = '0;
                        row_next   = row_reg + RW'(1);
                        cnt_next   = '0;
                        state_next = ST_SETTLE;
                    end
                    tccc_pkg::CHAR_CR:
                    begin
                        col_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_SETTLE;
                    end
                    tccc_pkg::CHAR_TAB:
                    begin
                        rem_start  = 1'b1;
                        state_next = ST_TAB;
                    end
                    default:
                    begin
                        cnt_next   = TW'(1);
                        state_next = ST_PUT;
                    end
                endcase
            end
            ST_TAB:
            begin
                if (rem_done)
                begin
                    cnt_next   = TW'(TAB_STOP) - rem_value;
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    col_next   = col_reg + CW'(1);
                    cnt_next   = cnt_reg - TW'(1);
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                if (row_wrap < rows_eff)
                begin
                    col_next   = col_wrap;
                    row_next   = row_wrap;
                    state_next = (cnt_reg != '0) ? ST_PUT : ST_MUL;
                end
                else if (out_free)
                begin
                    emit                = 1'b1;
                    res_next.kind       = tccc_pkg::KIND_SCROLL;
                    res_next.column     = tccc_pkg::COLUMN_W'(col_wrap);
                    res_next.row        = tccc_pkg::ROW_W'(rows_eff - RW'(1));
                    res_next.glyph_code = tccc_pkg::CHAR_SPACE;
                    col_next            = col_wrap;
                    row_next            = rows_eff - RW'(1);
                    state_next          = (cnt_reg != '0) ? ST_PUT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_CURSOR;
            end
            ST_CURSOR:
            begin
                if (out_free)
                begin
                    emit                     = 1'b1;
                    res_next.kind            = tccc_pkg::KIND_CURSOR;
                    res_next.glyph_code      = '0;
                    res_next.foreground      = '0;
                    res_next.cursor_position = tccc_pkg::POS_W'(pos_sum);
                    res_next.last            = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            cols_cfg_reg  <= tccc_pkg::COLUMNS_RESET;
            rows_cfg_reg  <= tccc_pkg::ROWS_RESET;
            color_reg     <= tccc_pkg::COLOR_RESET;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    tccc_pkg::CFG_COLUMNS: cols_cfg_reg <= cfg_data[tccc_pkg::COLCFG_W-1:0];
                    tccc_pkg::CFG_ROWS:    rows_cfg_reg <= cfg_data[tccc_pkg::ROWCFG_W-1:0];
                    tccc_pkg::CFG_COLOR:   color_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= character;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PW'(row_reg) * PW'(cols_eff);
        end
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = res_reg.kind;
    assign column          = res_reg.column;
    assign row             = res_reg.row;
    assign glyph_code      = res_reg.glyph_code;
    assign foreground      = res_reg.foreground;
    assign cursor_position = res_reg.cursor_position;
    assign last            = res_reg.last;

endmodule

/* hdl/tccc_rem.sv */
// remainder by a constant divisor through reciprocal multiplication
// depends on nothing; used by the top level for tab stop arithmetic
module tccc_rem #(
    parameter int DIVISOR = 4,
    parameter int WIDTH   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [WIDTH-1:0]                   dividend,
    output logic                               done,
    output logic [$clog2(DIVISOR+1)-1:0]       remainder
);

    localparam int DW    = $clog2(DIVISOR + 1);
    localparam int SH    = WIDTH + DW;
    localparam int PRW   = WIDTH + SH;
    localparam int QW    = WIDTH + DW;
    localparam int RECIP = ((2 ** SH) + DIVISOR - 1) / DIVISOR;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] dvd_reg;
    logic [PRW-1:0]   prod_reg;
    logic [DW-1:0]    rem_reg;
    logic [WIDTH-1:0] quotient;
    logic [QW-1:0]    diff;

    // quotient from the scaled reciprocal, remainder by one constant multiply back
    assign quotient  = prod_reg[SH +: WIDTH];
    assign diff      = QW'(dvd_reg) - QW'(quotient) * QW'(DIVISOR);
    assign busy_next = start;
    assign done_next = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            prod_reg <= PRW'(dividend) * PRW'(RECIP);
        end
        if (busy_reg)
        begin
            rem_reg <= diff[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/tccc_checker.sv */
// port-level checker for the text console cursor control unit, bound to the top level
// depends on tccc_pkg and text_console_cursor_control_unit_assert.svh
`include "text_console_cursor_control_unit_assert.svh"

module tccc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [tccc_pkg::KIND_W-1:0]      kind,
    input logic [tccc_pkg::COLUMN_W-1:0]    column,
    input logic [tccc_pkg::CHAR_W-1:0]      glyph_code,
    input logic [tccc_pkg::COLOR_W-1:0]     foreground,
    input logic [tccc_pkg::POS_W-1:0]       cursor_position,
    input logic                             last
);

    // busy right after taking an item
    `TCCC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")

    // only the cursor update closes an item
    `TCCC_ASSERT_IMPLY(a_last_is_cursor, clk, rst_n, out_valid, last == (kind == tccc_pkg::KIND_CURSOR), "last flag mismatch")

    // cursor updates carry no glyph and no color
    `TCCC_ASSERT_IMPLY(a_cursor_clean, clk, rst_n, out_valid && kind == tccc_pkg::KIND_CURSOR, glyph_code == '0 && foreground == '0, "cursor update payload")

    // while idle only the closing result may still be pending
    `TCCC_ASSERT_IMPLY(a_idle_pending_last, clk, rst_n, in_ready && out_valid, last, "idle with open item")

    // stalled result holds
    `TCCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(column) && $stable(cursor_position), "result dropped")

endmodule

bind text_console_cursor_control_unit tccc_checker u_tccc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .column          (column),
    .glyph_code      (glyph_code),
    .foreground      (foreground),
    .cursor_position (cursor_position),
    .last            (last)
);
